### sv/hf_pkg.sv
// ----------------------------------------------------------------------------
// hf_pkg: shared types and constants for the Hamilton filter step
// Payload structs, sequencer state codes and fixed-point constants.
// ----------------------------------------------------------------------------
package hf_pkg;

    localparam int unsigned MaxRegimes = 4;
    localparam logic [15:0] OneQ15     = 16'h8000;

    typedef struct packed {
        logic        series_start;
        logic [31:0] lik_0;
        logic [31:0] lik_1;
        logic [31:0] lik_2;
        logic [31:0] lik_3;
    } t_in_item;

    typedef struct packed {
        logic [31:0] mix_likelihood;
        logic [15:0] prob_0;
        logic [15:0] prob_1;
        logic [15:0] prob_2;
        logic [15:0] prob_3;
        logic        zero_sum_flag;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_WEIGHT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

    // Start request and operands to the divider; done comes back separately.
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [49:0] den;
    } t_div_req;

endpackage

### sv/hf_div.sv
// ----------------------------------------------------------------------------
// hf_div: radix-2 restoring divider
// Unsigned 64-bit by 50-bit division with a quotient below 2^16, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module hf_div
    import hf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [15:0] o_quot
);

    localparam int unsigned NumW = 64;

    logic [NumW-1:0] r_num, n_num;
    logic [49:0]     r_rem, n_rem;
    logic [49:0]     r_den, n_den;
    logic [5:0]      r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [50:0]     w_shift;
    logic [51:0]     w_diff;

    always_comb begin
        w_shift = {r_rem, r_num[NumW-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_den};
        n_num   = r_num;
        n_rem   = r_rem;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            // Quotient fits 16 bits, so the top 48 numerator bits start below den.
            n_num  = {i_req.num[15:0], 48'd0};
            n_den  = i_req.den;
            n_rem  = 50'(i_req.num[63:16]);
            n_cnt  = 6'd16;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[NumW-2:0], ~w_diff[51]};
            n_rem = w_diff[51] ? w_shift[49:0] : w_diff[49:0];
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    // Quotient never exceeds 32768, so the low bits hold it.
    assign o_done = r_done;
    assign o_quot = r_num[15:0];

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_req.start) |-> r_cnt != 6'd0) else $error("busy with zero count");
    a_done_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without work");

endmodule

### sv/hf_core.sv
// ----------------------------------------------------------------------------
// hf_core: sequencer and shared multiply-accumulate unit
// Runs prediction MACs, weighting and normalization for one time step.
// ----------------------------------------------------------------------------
module hf_core
    import hf_pkg::*;
#(
    parameter int unsigned NUM_STATES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [4*64-1:0]   i_trans,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in_item          i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_item         o_data
);

    localparam int unsigned NReg = (NUM_STATES < 1) ? 1 :
        ((NUM_STATES > MaxRegimes) ? MaxRegimes : NUM_STATES);
    localparam logic [15:0] Uniform = 16'(32'(OneQ15) / NReg);

    t_state      r_state, n_state;
    logic [15:0] r_prob [MaxRegimes];
    logic [15:0] n_prob [MaxRegimes];
    logic [48:0] r_w    [MaxRegimes];
    logic [48:0] n_w    [MaxRegimes];
    logic [31:0] r_lik  [MaxRegimes];
    logic [1:0]  r_i, n_i, r_j, n_j;
    logic [33:0] r_acc, n_acc;
    logic [31:0] r_prod, n_prod;
    logic        r_pv, n_pv;
    logic [50:0] r_sum, n_sum;
    logic        r_flag, n_flag;
    logic        r_ov, n_ov;
    t_out_item   r_out, n_out;
    t_div_req    w_req;
    logic        w_ddone;
    logic [15:0] w_quot;
    logic [15:0] w_tf;
    logic [34:0] w_accr;
    logic [18:0] w_pred;
    logic [15:0] w_predsat;
    logic [47:0] w_wmul;
    logic [51:0] w_mixr;
    logic [15:0] w_outp [MaxRegimes];
    logic        w_last_j, w_last_i;

    hf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_ddone),
        .o_quot (w_quot)
    );

    always_comb begin
        w_tf      = i_trans[{r_j, r_i, 4'b0000} +: 16];
        w_accr    = {1'b0, r_acc} + 35'h4000;
        w_pred    = w_accr[33:15];
        w_predsat = (w_pred > 19'(OneQ15)) ? OneQ15 : w_pred[15:0];
        w_wmul    = 48'(w_predsat) * 48'(r_lik[r_i]);
        w_mixr    = {1'b0, r_sum} + 52'h4000;
        w_last_j  = (32'(r_j) == NReg - 1);
        w_last_i  = (32'(r_i) == NReg - 1);
        for (int k = 0; k < MaxRegimes; k++) begin
            w_outp[k] = (k < NReg) ? r_prob[k] : 16'd0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_prob  = r_prob;
        n_w     = r_w;
        n_i     = r_i;
        n_j     = r_j;
        n_acc   = r_acc;
        n_prod  = r_prod;
        n_pv    = 1'b0;
        n_sum   = r_sum;
        n_flag  = r_flag;
        n_ov    = r_ov;
        n_out   = r_out;
        w_req   = '{start: 1'b0, num: {r_w[r_i], 15'd0} + 64'(r_sum[50:1]),
                    den: r_sum[49:0]};
        o_stall = 1'b1;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_i    = '0;
                    n_j    = '0;
                    n_acc  = '0;
                    n_sum  = '0;
                    n_flag = 1'b0;
                    if (i_data.series_start) begin
                        for (int k = 0; k < MaxRegimes; k++) begin
                            n_prob[k] = (k < NReg) ? Uniform : 16'd0;
                        end
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                // Multiply stage feeds the accumulate stage through the registered product, added in the next cycle.
                n_prod = 32'(w_tf) * 32'(r_prob[r_j]);
                n_pv   = 1'b1;
                n_j    = r_j + 2'd1;
                if (w_last_j) begin
                    n_j     = '0;
                    n_state = ST_WEIGHT;
                end
                if (r_pv) begin
                    n_acc = r_acc + 34'(r_prod);
                end
            end
            ST_WEIGHT: begin
                if (r_pv) begin
                    n_acc = r_acc + 34'(r_prod);
                end else begin
                    n_w[r_i] = {1'b0, w_wmul};
                    n_sum    = r_sum + 51'(w_wmul);
                    n_acc    = '0;
                    if (w_last_i) begin
                        n_i     = '0;
                        n_state = ST_DIV_START;
                    end else begin
                        n_i     = r_i + 2'd1;
                        n_state = ST_MAC;
                    end
                end
            end
            ST_DIV_START: begin
                if (r_sum == '0) begin
                    n_flag  = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    w_req.start = 1'b1;
                    n_state     = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (w_ddone) begin
                    n_prob[r_i] = w_quot;
                    if (w_last_i) begin
                        n_state = ST_OUT;
                    end else begin
                        n_i         = r_i + 2'd1;
                        w_req.start = 1'b1;
                        w_req.num   = {r_w[r_i + 2'd1], 15'd0} + 64'(r_sum[50:1]);
                    end
                end
            end
            ST_OUT: begin
                // Hold until the previous result has left.
                if (!r_ov || !i_stall) begin
                    n_out.mix_likelihood = (r_flag || r_sum == '0) ? 32'd0 :
                        ((w_mixr[51:47] != '0) ? 32'hFFFF_FFFF : w_mixr[46:15]);
                    n_out.prob_0        = w_outp[0];
                    n_out.prob_1        = w_outp[1];
                    n_out.prob_2        = w_outp[2];
                    n_out.prob_3        = w_outp[3];
                    n_out.zero_sum_flag = r_flag;
                    n_ov                = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
            for (int k = 0; k < MaxRegimes; k++) begin
                r_prob[k] <= (k < NReg) ? Uniform : 16'd0;
            end
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_pv    <= n_pv;
            r_prob  <= n_prob;
        end
        r_w    <= n_w;
        r_i    <= n_i;
        r_j    <= n_j;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_sum  <= n_sum;
        r_flag <= n_flag;
        r_out  <= n_out;
        if (r_state == ST_IDLE && i_valid) begin
            r_lik[0] <= i_data.lik_0;
            r_lik[1] <= i_data.lik_1;
            r_lik[2] <= i_data.lik_2;
            r_lik[3] <= i_data.lik_3;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("accepting while busy");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_ov && $stable(r_out))) else $error("result lost");
    a_div_only_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ddone |-> r_state == ST_DIV_WAIT) else $error("stray divider result");
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.zero_sum_flag) |-> r_out.mix_likelihood == 32'd0)
        else $error("flag with nonzero mix");

endmodule

### sv/hamilton_filter_step.sv
// ----------------------------------------------------------------------------
// hamilton_filter_step: Markov-switching Hamilton filter, one step per item
// APB-programmed transition rows, sequenced MAC and serial normalization.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | i_valid / o_stall  | i_data  (t_in_item)
//  out     | output    | o_valid / i_stall  | o_data  (t_out_item)
//  cfg     | input     | APB psel/penable   | pwdata 64 bit, paddr 5 bit
//
// A step runs, from one accepted transaction to the next, the prediction MACs
// and weighting for each regime, then one pass per regime through the shared
// bit-serial divider, plus sequencing; the divider dominates the step time.
// A zero weight sum skips the divider; a series start goes straight to output.
// Reset gives the identity transition matrix and uniform probabilities.
// A waiting result holds under i_stall; the next one waits behind it.
module hamilton_filter_step
    import hf_pkg::*;
#(
    parameter int unsigned NUM_STATES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0] r_trans [MaxRegimes];
    logic [1:0]  w_idx;

    assign w_idx  = paddr[4:3];
    assign pready = 1'b1;
    assign prdata = r_trans[w_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MaxRegimes; k++) begin
                r_trans[k] <= 64'(OneQ15) << (16 * k);
            end
        end else if (psel && penable && pwrite) begin
            r_trans[w_idx] <= pwdata;
        end
    end

    hf_core #(.NUM_STATES(NUM_STATES)) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_trans({r_trans[3], r_trans[2], r_trans[1], r_trans[0]}),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

endmodule
